/* sv/dqtk_pkg.sv */
`default_nettype none
package dqtk_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 8;
  localparam int unsigned RID_W           = 8;
  localparam int unsigned RAW_W           = 32;
  localparam int unsigned RATE_W          = 8;
  localparam int unsigned UNIT_W          = 21;
  localparam int unsigned DEPTH_W         = 16;
  localparam int unsigned ENTRY_W         = 32;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned FILL_W          = 4;
  localparam int unsigned IN_DATA_W       = 48;
  localparam int unsigned OUT_DATA_W      = 32;

  localparam logic [DEPTH_W-1:0]  DEPTH_SAT  = 16'hffff;
  localparam logic [UNIT_W-1:0]   UNIT_RESET = 21'd1;

  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_STORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SMALL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic scan_start;
    logic wr_en;
  } tbl_ctl_t;

  typedef struct packed {
    logic               scan_done;
    logic [DEPTH_W-1:0] least_depth;
  } tbl_sts_t;

  function automatic logic [ENTRY_W-1:0] pack_entry(
    input logic [RID_W-1:0]   rid,
    input logic [DEPTH_W-1:0] depth,
    input logic [RATE_W-1:0]  rate
  );
    return {rate, depth, rid};
  endfunction

endpackage
`default_nettype wire

/* sv/dqtk_div.sv */
`default_nettype none
module dqtk_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dqtk_pkg::RAW_W-1:0]    dividend,
  input  wire logic [dqtk_pkg::UNIT_W-1:0]   divisor,
  output logic                               done,
  output logic [dqtk_pkg::RAW_W-1:0]         quotient
);
  import dqtk_pkg::*;

  localparam int unsigned CNT_W = $clog2(RAW_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RAW_W-1:0]   q_r, q_nxt;
  logic [UNIT_W-1:0]  rem_r, rem_nxt;
  logic [UNIT_W-1:0]  dvs_r, dvs_nxt;
  logic [UNIT_W:0]    trial;
  logic [UNIT_W:0]    diff;
  logic               ge;

  assign trial = {rem_r, q_r[RAW_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RAW_W - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[RAW_W-2:0], ge};
      rem_nxt = ge ? diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

/* sv/dqtk_table.sv */
`default_nettype none
module dqtk_table #(
  parameter int unsigned MAX_ENTRIES = dqtk_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dqtk_pkg::tbl_ctl_t            ctl,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [dqtk_pkg::ENTRY_W-1:0]  wr_data,
  output dqtk_pkg::tbl_sts_t                 sts,
  output logic [AW-1:0]                      min_idx
);
  import dqtk_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_q_r;

  logic               scan_on_r, scan_on_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [DEPTH_W-1:0] min_d_r, min_d_nxt;
  logic [AW-1:0]      min_i_r, min_i_nxt;
  logic               done_r, done_nxt;
  logic [DEPTH_W-1:0] rd_depth;
  logic [AW-1:0]      rd_addr;

  assign rd_addr  = rd_idx_r[AW-1:0];
  assign rd_depth = rd_q_r[RID_W +: DEPTH_W];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    scan_on_nxt = scan_on_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    min_d_nxt   = min_d_r;
    min_i_nxt   = min_i_r;
    done_nxt    = 1'b0;
    if (ctl.scan_start) begin
      scan_on_nxt = 1'b1;
      rd_idx_nxt  = '0;
    end else if (scan_on_r) begin
      if (rd_idx_r < CW'(MAX_ENTRIES)) begin
        rd_idx_nxt  = rd_idx_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_addr;
      end else begin
        scan_on_nxt = 1'b0;
      end
    end
    if (cmp_vld_r) begin
      if (cmp_idx_r == '0 || rd_depth < min_d_r) begin
        min_d_nxt = rd_depth;
        min_i_nxt = cmp_idx_r;
      end
      if (cmp_idx_r == AW'(MAX_ENTRIES - 1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r <= 1'b0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      scan_on_r <= scan_on_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      done_r    <= done_nxt;
    end
    cmp_idx_r <= cmp_idx_nxt;
    min_d_r   <= min_d_nxt;
    min_i_r   <= min_i_nxt;
  end

  assign sts.scan_done   = done_r;
  assign sts.least_depth = min_d_r;
  assign min_idx         = min_i_r;

endmodule
`default_nettype wire

/* sv/deepest_queue_top_k_record_top.sv */
// Each item passes through the 32-step serial divider and, once the table is full, also
//   through the one-entry-a-cycle minimum scan over the table memory before its result
//   reaches out_tvalid. The next item is taken once the result is queued.
// Reset: clears the fill count and control state, sets depth_unit to 1; table undefined.
`default_nettype none
module deepest_queue_top_k_record_top #(
  parameter int unsigned MAX_ENTRIES = dqtk_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [dqtk_pkg::UNIT_W-1:0]      cfg_wr_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // route_id[7:0], raw_depth[39:8], max_rate[47:40]
  input  wire logic [dqtk_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], slot[4:2], fill_count[8:5], scaled_depth[24:9], zero[31:25]
  output logic [dqtk_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import dqtk_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  state_t               state_r, state_nxt;
  logic [UNIT_W-1:0]    unit_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [RID_W-1:0]     rid_r, rid_nxt;
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [AW-1:0]        res_slot_r, res_slot_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 div_done;
  logic [RAW_W-1:0]     quotient;
  tbl_ctl_t             tbl_ctl;
  tbl_sts_t             tbl_sts;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        min_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  dqtk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (in_tdata[RID_W +: RAW_W]),
    .divisor  (unit_r),
    .done     (div_done),
    .quotient (quotient)
  );

  dqtk_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_addr (wr_addr),
    .wr_data (pack_entry(rid_r, depth_r, rate_r)),
    .sts     (tbl_sts),
    .min_idx (min_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rid_nxt        = rid_r;
    rate_nxt       = rate_r;
    depth_nxt      = depth_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_data_nxt   = out_data_r;
    tbl_ctl        = '0;
    wr_addr        = count_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rid_nxt   = in_tdata[RID_W-1:0];
          rate_nxt  = in_tdata[RID_W+RAW_W +: RATE_W];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          depth_nxt = (quotient >= RAW_W'(DEPTH_SAT)) ? DEPTH_SAT : quotient[DEPTH_W-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_slot_nxt = '0;
        if (depth_r == '0) begin
          res_status_nxt = STAT_REJECT;
          state_nxt      = ST_RESULT;
        end else if (count_r < CW'(MAX_ENTRIES)) begin
          tbl_ctl.wr_en  = 1'b1;
          res_slot_nxt   = count_r[AW-1:0];
          res_status_nxt = STAT_STORED;
          count_nxt      = count_r + 1'b1;
          state_nxt      = ST_RESULT;
        end else begin
          tbl_ctl.scan_start = 1'b1;
          state_nxt          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        wr_addr = min_idx;
        if (tbl_sts.scan_done) begin
          if (depth_r > tbl_sts.least_depth) begin
            tbl_ctl.wr_en  = 1'b1;
            res_slot_nxt   = min_idx;
            res_status_nxt = STAT_STORED;
          end else begin
            res_status_nxt = STAT_SMALL;
          end
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = OUT_DATA_W'({depth_r, FILL_W'(count_r), SLOT_W'(res_slot_r),
                                      res_status_r});
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      unit_r    <= UNIT_RESET;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        unit_r <= cfg_wr_data;
      end
    end
    rid_r        <= rid_nxt;
    rate_r       <= rate_nxt;
    depth_r      <= depth_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* sim/tb_deepest_queue_top_k_record_top.sv */
`timescale 1ns / 1ps
module tb_deepest_queue_top_k_record_top;
  import dqtk_pkg::*;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic [FILL_W-1:0]   fill;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } hop_result_t;

  class depth_table_board;
    logic [ENTRY_W-1:0] entries [MAX_ENTRIES_DEF];
    int unsigned        fill;
    logic [UNIT_W-1:0]  unit;
    hop_result_t        expected_q [$];
    int unsigned        errors;

    function new();
      fill   = 0;
      unit   = UNIT_RESET;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned least_depth();
      int unsigned low;
      if (fill < MAX_ENTRIES_DEF) return 0;
      low = entries[0][23:8];
      foreach (entries[i]) if (entries[i][23:8] < low) low = entries[i][23:8];
      return low;
    endfunction

    function void note_report(logic [RID_W-1:0] rid, logic [RAW_W-1:0] raw,
                              logic [RATE_W-1:0] rate);
      logic [RAW_W-1:0] quot;
      hop_result_t      r;
      int unsigned      low_i;
      quot = (unit == '0) ? 32'hffff_ffff : raw / {11'd0, unit};
      r = '0;
      r.depth = (quot < {16'd0, DEPTH_SAT}) ? quot[DEPTH_W-1:0] : DEPTH_SAT;
      if (r.depth == '0) begin
        r.status = STAT_REJECT;
      end else if (fill < MAX_ENTRIES_DEF) begin
        r.slot = fill[SLOT_W-1:0];
        entries[fill] = {rate, r.depth, rid};
        fill++;
        r.status = STAT_STORED;
      end else begin
        low_i = 0;
        for (int i = 1; i < MAX_ENTRIES_DEF; i++) begin
          if (entries[i][23:8] < entries[low_i][23:8]) low_i = i;
        end
        if (r.depth > entries[low_i][23:8]) begin
          entries[low_i] = {rate, r.depth, rid};
          r.slot = low_i[SLOT_W-1:0];
          r.status = STAT_STORED;
        end else begin
          r.status = STAT_SMALL;
        end
      end
      r.fill = fill[FILL_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      hop_result_t want;
      hop_result_t got;
      got = data[24:0];
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot expected %0d got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.fill !== want.fill) begin
        $error("fill_count expected %0d got %0d", want.fill, got.fill);
        errors++;
      end
      if (got.depth !== want.depth) begin
        $error("scaled_depth expected %0d got %0d", want.depth, got.depth);
        errors++;
      end
      if (data[31:25] !== '0) begin
        $error("pad bits expected 0 got %h", data[31:25]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [UNIT_W-1:0]     cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  calm;

  depth_table_board board = new();

  deepest_queue_top_k_record_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  task automatic send_report(input logic [RID_W-1:0] rid, input logic [RAW_W-1:0] raw,
                             input logic [RATE_W-1:0] rate);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rate, raw, rid};
    do @(posedge clk); while (!in_tready);
    board.note_report(rid, raw, rate);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_unit(input logic [UNIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    board.unit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [RAW_W-1:0]  directed_raw [19];
    logic [UNIT_W-1:0] units [8];
    int unsigned       phase_len [8];
    int unsigned       level;
    int unsigned       kind;
    longint unsigned   target;
    longint unsigned   span;
    logic [RAW_W-1:0]  raw;

    directed_raw = '{32'd0, 32'd5, 32'd5, 32'd3, 32'd3, 32'd9, 32'd10, 32'd11,
                     32'hffff_ffff, 32'd3, 32'd2, 32'd4, 32'd4, 32'd4, 32'd6,
                     32'd65535, 32'd65534, 32'd1, 32'd0};
    units = '{21'd1, 21'd3, 21'd1000, 21'd65536, 21'd5, 21'd1048576, 21'h1f_ffff, 21'd0};
    phase_len = '{205, 205, 205, 205, 205, 205, 205, 100};
    level = 0;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    calm        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_raw[k]) begin
      send_report((k % 2) ? 8'hff : 8'h00, directed_raw[k], (k % 3 == 0) ? 8'hff : 8'h00);
    end

    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      write_unit(units[p]);
      calm = (p == 1);
      if (board.least_depth() > level) level = board.least_depth();
      for (int n = 0; n < phase_len[p]; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          raw = (units[p] == '0) ? $urandom() : $urandom_range(0, units[p] - 1);
        end else if (kind < 18) begin
          if (units[p] >= 21'd65536 || units[p] == '0) begin
            raw = $urandom();
          end else begin
            span = longint'(level) * units[p];
            raw = $urandom_range(0, span[31:0]);
          end
        end else begin
          target = level + $urandom_range(0, 63);
          if (units[p] == '0) begin
            raw = $urandom();
          end else begin
            if (target > 64'hffff_ffff / units[p]) target = 64'hffff_ffff / units[p];
            span = target * units[p] + $urandom_range(0, units[p] - 1);
            raw = (span > 64'hffff_ffff) ? 32'hffff_ffff : span[31:0];
          end
        end
        send_report($urandom_range(0, 255), raw, $urandom_range(0, 255));
        level += $urandom_range(0, 1);
      end
    end

    calm = 1'b0;
    wait_for_results();
    if (board.pending() != 0) $error("%0d result items never arrived", board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
